// ===== rtl/bst_pkg.sv =====
// bst_pkg: shared types and constants for the byte set table
// used by the channel interfaces and by byte_set_table_unit
// no dependencies
package bst_pkg;

  // payload widths, fixed by the transaction format
  localparam int unsigned ACT_W = 2;
  localparam int unsigned VAL_W = 8;
  localparam int unsigned CNT_W = 9;

  // action codes carried by a request
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  // controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_LAST = 5'b00100,
    ST_MOVE = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

endpackage

// ===== rtl/bst_if.sv =====
// bst request and response channel interfaces, valid/ready handshake
// depends on bst_pkg for the action type and payload widths
interface bst_req_if import bst_pkg::*; ();
  logic             valid;
  logic             ready;
  action_e          action;
  logic [VAL_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface bst_rsp_if import bst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic             found;
  logic [CNT_W-1:0] count;

  modport source (output valid, status, found, count, input ready);
  modport sink   (input valid, status, found, count, output ready);
endinterface

// ===== rtl/byte_set_table_unit.sv =====
// byte_set_table_unit: set of distinct byte values kept in a single memory
// depends on bst_pkg and on the bst_req_if / bst_rsp_if channel interfaces
//
// The set lives in a CAPACITY-entry memory with synchronous registered reads,
// plus an element count. Requests are taken one at a time. Insert, remove and
// search scan the stored entries one per cycle through the memory read port;
// remove then reads the last entry and writes it over the vacated slot, and
// clear resets the count without a scan. A new request is not accepted until
// the response of the current one has been loaded into the output register.
// A finished response sits in that output register, and the next request is
// accepted while it waits. There is no clearing pass after reset: only
// entries below the count are ever used.
module byte_set_table_unit import bst_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bst_req_if.sink      req_i,
  bst_rsp_if.source    rsp_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // entry memory
  logic [VAL_W-1:0] entries_mem [CAPACITY];
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [IdxW-1:0]  mem_raddr;
  logic [VAL_W-1:0] rd_data_q;

  // control and working registers
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  action_e          action_q, action_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             pend_q, pend_d;
  logic [IdxW-1:0]  pend_idx_q, pend_idx_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic             res_status_q, res_status_d;
  logic             res_found_q, res_found_d;

  // response register
  logic             out_vld_q, out_vld_d;
  logic             out_status_q, out_status_d;
  logic             out_found_q, out_found_d;
  logic [CNT_W-1:0] out_count_q, out_count_d;

  logic             issue_more;
  logic             hit;
  logic             miss;
  logic [CNT_W-1:0] last_cnt;

  assign req_i.ready  = (state_q == ST_IDLE);
  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.found  = out_found_q;
  assign rsp_o.count  = out_count_q;

  // scan bookkeeping: data for pend_idx_q arrives in the cycle after its read
  assign issue_more = (issue_q < count_q);
  assign hit        = pend_q && (rd_data_q == value_q);
  assign miss       = !pend_q && !issue_more;
  assign last_cnt   = count_q - CNT_W'(1);

  // memory port, read and write in one clocked block
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entries_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= entries_mem[mem_raddr];
  end

  // next-state and datapath control
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    action_d     = action_q;
    value_d      = value_q;
    issue_d      = issue_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    hit_idx_d    = hit_idx_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    out_vld_d    = out_vld_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_count_d  = out_count_q;
    mem_we       = 1'b0;
    mem_waddr    = count_q[IdxW-1:0];
    mem_wdata    = value_q;
    mem_raddr    = issue_q[IdxW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          action_d = req_i.action;
          value_d  = req_i.value;
          issue_d  = '0;
          pend_d   = 1'b0;
          if (req_i.action == ACT_CLEAR) begin
            count_d      = '0;
            res_status_d = 1'b0;
            res_found_d  = 1'b0;
            state_d      = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue the next read while comparing the previous one
        pend_d     = issue_more;
        pend_idx_d = issue_q[IdxW-1:0];
        if (issue_more) begin
          issue_d = issue_q + CNT_W'(1);
        end
        if (hit || miss) begin
          res_found_d  = 1'b0;
          res_status_d = 1'b0;
          state_d      = ST_RESP;
          case (action_q)
            ACT_SEARCH: begin
              res_found_d = hit;
            end
            ACT_INSERT: begin
              if (hit || (count_q >= CNT_W'(CAPACITY))) begin
                res_status_d = 1'b1;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            ACT_REMOVE: begin
              if (hit) begin
                hit_idx_d = pend_idx_q;
                state_d   = ST_LAST;
              end else begin
                res_status_d = 1'b1;
              end
            end
            default: begin
              res_status_d = 1'b0;
            end
          endcase
        end
      end

      ST_LAST: begin
        // fetch the last stored entry
        mem_raddr = last_cnt[IdxW-1:0];
        state_d   = ST_MOVE;
      end

      ST_MOVE: begin
        // move the last entry into the vacated slot
        mem_we    = 1'b1;
        mem_waddr = hit_idx_q;
        mem_wdata = rd_data_q;
        count_d   = last_cnt;
        state_d   = ST_RESP;
      end

      ST_RESP: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_count_d  = count_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      issue_q   <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
      issue_q   <= issue_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    action_q     <= action_d;
    value_q      <= value_d;
    pend_idx_q   <= pend_idx_d;
    hit_idx_q    <= hit_idx_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_count_q  <= out_count_d;
  end

endmodule

// ===== test/tb_byte_set_table_unit.sv =====
`timescale 1ns / 1ps
// tb_byte_set_table_unit: self-checking testbench for the byte set table
// depends on bst_pkg, bst_req_if / bst_rsp_if and byte_set_table_unit
module tb_byte_set_table_unit;
  import bst_pkg::*;

  localparam int unsigned DEPTH          = 256;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned HOLD_AFTER     = 150;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned MIXED_ITEMS    = 560;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [CNT_W-1:0] count;
  } set_result_t;

  // predicts the set behaviour and holds the outstanding responses
  class set_scoreboard;
    logic [VAL_W-1:0] slots [DEPTH];
    int unsigned      n_elem;
    set_result_t      awaited [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      per_action [4];
    int unsigned      peak;

    function new();
      n_elem  = 0;
      errors  = 0;
      checked = 0;
      peak    = 0;
      foreach (per_action[i]) per_action[i] = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    // index of a stored value, or -1 when absent
    function int locate(logic [VAL_W-1:0] v);
      for (int i = 0; i < int'(n_elem); i++) begin
        if (slots[i] == v) return i;
      end
      return -1;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // apply one accepted request and queue its expected response
    function void note_request(action_e a, logic [VAL_W-1:0] v);
      set_result_t r;
      int          pos;
      r = '0;
      per_action[a]++;
      case (a)
        ACT_INSERT: begin
          if (n_elem >= DEPTH || locate(v) >= 0) begin
            r.status = 1'b1;
          end else begin
            slots[n_elem] = v;
            n_elem++;
          end
        end
        ACT_REMOVE: begin
          pos = (n_elem == 0) ? -1 : locate(v);
          if (pos < 0) begin
            r.status = 1'b1;
          end else begin
            // vacated slot is refilled from the last entry
            slots[pos] = slots[n_elem-1];
            n_elem--;
          end
        end
        ACT_SEARCH: begin
          r.found = (locate(v) >= 0);
        end
        default: begin
          n_elem = 0;
        end
      endcase
      r.count = n_elem[CNT_W-1:0];
      if (n_elem > peak) peak = n_elem;
      awaited.push_back(r);
    endfunction

    // compare one accepted response with the oldest expectation
    function void check_response(logic status, logic found, logic [CNT_W-1:0] count);
      set_result_t e;
      if (awaited.size() == 0) begin
        $error("response with none expected: status %0d found %0d count %0d",
               status, found, count);
        errors++;
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (status !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (found !== e.found) begin
        $error("found mismatch: expected %0d, actual %0d", e.found, found);
        errors++;
      end
      if (count !== e.count) begin
        $error("count mismatch: expected %0d, actual %0d", e.count, count);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  bst_req_if   req_if ();
  bst_rsp_if   rsp_if ();

  set_scoreboard sb;
  bit            no_idle;
  int unsigned   rsp_seen;
  int unsigned   quiet_cycles;

  byte_set_table_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // drive one request and wait for its transaction
  task automatic send_item(input action_e a, input logic [VAL_W-1:0] v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid  = 1'b1;
    req_if.action = a;
    req_if.value  = v;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(a, v);
  endtask

  // a value currently held in the set
  function automatic logic [VAL_W-1:0] held_value();
    return sb.slots[$urandom_range(0, sb.n_elem - 1)];
  endfunction

  // a value not held in the set, any value once the set is full
  function automatic logic [VAL_W-1:0] missing_value();
    logic [VAL_W-1:0] v;
    v = VAL_W'($urandom_range(0, 255));
    if (sb.n_elem >= DEPTH) return v;
    while (sb.locate(v) >= 0) v = v + 8'd1;
    return v;
  endfunction

  // extremes and each special case
  task automatic run_directed();
    send_item(ACT_SEARCH, 8'h00);   // search on empty set
    send_item(ACT_REMOVE, 8'h05);   // remove from empty set
    send_item(ACT_INSERT, 8'h00);
    send_item(ACT_INSERT, 8'hFF);
    send_item(ACT_INSERT, 8'h00);   // duplicate insert
    send_item(ACT_INSERT, 8'hAA);
    send_item(ACT_INSERT, 8'h55);
    send_item(ACT_SEARCH, 8'hFF);
    send_item(ACT_SEARCH, 8'h55);
    send_item(ACT_SEARCH, 8'h01);   // absent
    send_item(ACT_REMOVE, 8'h80);   // absent, set not empty
    send_item(ACT_REMOVE, 8'h00);   // first entry, last one moves down
    send_item(ACT_SEARCH, 8'h55);
    send_item(ACT_SEARCH, 8'h00);
    send_item(ACT_REMOVE, 8'h55);   // now the first entry, last one moves down
    send_item(ACT_CLEAR,  8'h3C);
    send_item(ACT_SEARCH, 8'hFF);   // stale bits must not be seen
    send_item(ACT_REMOVE, 8'hFF);
    send_item(ACT_INSERT, 8'hFF);
    send_item(ACT_SEARCH, 8'hAA);
    send_item(ACT_CLEAR,  8'h00);
    send_item(ACT_CLEAR,  8'hFF);   // clear when already empty
  endtask

  // fill the set to capacity with every byte, probe it full, then empty it
  task automatic run_fill_and_drain();
    logic [VAL_W-1:0] order [DEPTH];
    logic [VAL_W-1:0] t;
    int               j;
    for (int i = 0; i < DEPTH; i++) order[i] = i[VAL_W-1:0];
    for (int i = DEPTH - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < DEPTH; i++) begin
      send_item(ACT_INSERT, order[i]);
      if ($urandom_range(0, 15) == 0) send_item(ACT_SEARCH, VAL_W'($urandom_range(0, 255)));
    end
    // insert on a full set
    repeat (4) send_item(ACT_INSERT, VAL_W'($urandom_range(0, 255)));
    for (int i = DEPTH - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < DEPTH; i++) begin
      send_item(ACT_REMOVE, order[i]);
      if ($urandom_range(0, 15) == 0) send_item(ACT_SEARCH, order[i]);
    end
    send_item(ACT_REMOVE, VAL_W'($urandom_range(0, 255)));
  endtask

  // random mix, mostly meaningful operations with some noise
  task automatic run_mixed(input int unsigned n);
    int unsigned sel;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 80 == 0) no_idle = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        send_item(action_e'($urandom_range(0, 3)), VAL_W'($urandom_range(0, 255)));
      end else if (sel < 55) begin
        send_item(ACT_INSERT, (sb.n_elem > 0 && $urandom_range(0, 4) == 0)
                              ? held_value() : missing_value());
      end else if (sel < 80) begin
        send_item(ACT_REMOVE, (sb.n_elem > 0 && $urandom_range(0, 3) != 0)
                              ? held_value() : missing_value());
      end else if (sel < 99) begin
        send_item(ACT_SEARCH, (sb.n_elem > 0 && $urandom_range(0, 1) == 0)
                              ? held_value() : missing_value());
      end else begin
        send_item(ACT_CLEAR, VAL_W'($urandom_range(0, 255)));
      end
    end
    no_idle = 1'b0;
  endtask

  // response side: random stalls plus one long hold-off
  initial begin
    int unsigned stall;
    bit          held;
    held         = 1'b0;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && rsp_seen >= HOLD_AFTER) begin
        held         = 1'b1;
        rsp_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  // response checking
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      sb.check_response(rsp_if.status, rsp_if.found, rsp_if.count);
      rsp_seen++;
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d responses outstanding", sb.outstanding());
        $display("tb_byte_set_table_unit: FAIL");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    sb            = new();
    no_idle       = 1'b0;
    rsp_seen      = 0;
    quiet_cycles  = 0;
    req_if.valid  = 1'b0;
    req_if.action = ACT_INSERT;
    req_if.value  = '0;
    rst_n         = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_fill_and_drain();
    run_mixed(MIXED_ITEMS);

    @(negedge clk);
    req_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered: %0d inserts, %0d removes, %0d searches, %0d clears",
             sb.per_action[ACT_INSERT], sb.per_action[ACT_REMOVE],
             sb.per_action[ACT_SEARCH], sb.per_action[ACT_CLEAR]);
    $display("responses checked: %0d, largest set size: %0d, errors: %0d",
             sb.checked, sb.peak, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_byte_set_table_unit: PASS");
    end else begin
      $display("tb_byte_set_table_unit: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bst_pkg.sv
rtl/bst_if.sv
rtl/byte_set_table_unit.sv
test/tb_byte_set_table_unit.sv
